FILE: src/gmb_pkg.sv
// Shared types and constants of the GPIO mode and blink controller.
`default_nettype none

package gmb_pkg;

  // Pin count and derived widths
  localparam int NUM_PINS    = 40;
  localparam int IDX_W       = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int VEC_W       = 40;
  localparam int PIN_W       = 8;
  localparam int CMD_W       = 8;
  localparam int ENTRY_PIN_W = 6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PINS - 1);

  // Usable pins after reset: 2, 4, 5, 12-19, 21-27, 32-36, 39
  localparam logic [VEC_W-1:0] MASK_RESET = 40'd683167182900;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_OUT_ENABLE  = 8'd0;
  localparam logic [CMD_W-1:0] CMD_IN_FLOAT    = 8'd1;
  localparam logic [CMD_W-1:0] CMD_IN_PULLUP   = 8'd2;
  localparam logic [CMD_W-1:0] CMD_IN_PULLDOWN = 8'd3;
  localparam logic [CMD_W-1:0] CMD_DRIVE_LOW   = 8'd10;
  localparam logic [CMD_W-1:0] CMD_DRIVE_HIGH  = 8'd11;
  localparam logic [CMD_W-1:0] CMD_BLINK_SLOW  = 8'd12;
  localparam logic [CMD_W-1:0] CMD_BLINK_FAST  = 8'd13;

  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_TICK = 2'd1,
    REQ_READ = 2'd2,
    REQ_RSVD = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_PIN = 2'd1,
    ST_BAD_CMD = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    MODE_UNSET       = 3'd0,
    MODE_IN_FLOAT    = 3'd1,
    MODE_IN_PULLUP   = 3'd2,
    MODE_IN_PULLDOWN = 3'd3,
    MODE_OUT_LOW     = 3'd4,
    MODE_OUT_HIGH    = 3'd5,
    MODE_BLINK_FAST  = 3'd6,
    MODE_BLINK_SLOW  = 3'd7
  } pin_mode_e;

  typedef enum logic [1:0] {
    SEQ_IDLE   = 2'd0,
    SEQ_SCAN   = 2'd1,
    SEQ_FINISH = 2'd2
  } seq_state_e;

endpackage

`default_nettype wire

FILE: src/gpio_mode_blink_controller.sv
// Top level of the GPIO mode and blink controller: sequencer, pin store and result register.
`default_nettype none

// Every request is handled by one pin-update unit that a sequencer steps over
// the pins, one pin per cycle unless a read entry stalls the scan, pins 0 to 39
// in order. A read request holds one entry back to know which is last, so each
// further entry waits until the previous word has left the result register.
// in_ready_o is high only between requests. The result register lets the next
// request be accepted while the final word of the previous one is still waiting.
// Pin modes and blink state sit in flip-flops cleared by reset, so no clearing
// pass is needed after reset. usable_pin_mask is written through
// cfg_we_i/cfg_wdata_i; the user must write it only between requests, as the
// block itself does not enforce this.
module gpio_mode_blink_controller (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration
  input  wire                                cfg_we_i,
  input  wire  [gmb_pkg::VEC_W-1:0]          cfg_wdata_i,
  // request channel
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [1:0]                         req_type_i,
  input  wire  [gmb_pkg::PIN_W-1:0]          pin_i,
  input  wire  [gmb_pkg::CMD_W-1:0]          command_i,
  input  wire  [gmb_pkg::VEC_W-1:0]          pin_levels_i,
  // result channel
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [1:0]                         status_o,
  output logic [gmb_pkg::VEC_W-1:0]          drive_enable_o,
  output logic [gmb_pkg::VEC_W-1:0]          drive_level_o,
  output logic [gmb_pkg::VEC_W-1:0]          pull_up_enable_o,
  output logic [gmb_pkg::VEC_W-1:0]          pull_down_enable_o,
  output logic                               entry_valid_o,
  output logic [gmb_pkg::ENTRY_PIN_W-1:0]    entry_pin_o,
  output logic                               entry_level_o,
  output logic                               last_o
);
  import gmb_pkg::*;

  // configuration register
  logic [VEC_W-1:0] usable_pin_mask_q;

  // sequencer
  seq_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q;

  // latched request
  req_e             req_q;
  logic [PIN_W-1:0] pin_q;
  logic [CMD_W-1:0] cmd_q;
  logic [VEC_W-1:0] levels_q;
  logic             pin_ok_q;

  // held-back read entry
  logic             pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0] pend_pin_q, pend_pin_d;
  logic             pend_level_q, pend_level_d;

  // pin store
  pin_mode_e mode_q  [NUM_PINS];
  logic      level_q [NUM_PINS];
  logic      phase_q [NUM_PINS];

  // result register
  logic             out_valid_q;
  status_e          status_q;
  logic [VEC_W-1:0] de_q, dl_q, pu_q, pd_q;
  logic             ev_q, el_q, last_q;
  logic [IDX_W-1:0] ep_q;

  // shared pin-update unit
  pin_mode_e mode_cur, mode_nx;
  logic      lvl_cur, lvl_nx, ph_cur, ph_nx;
  logic      mask_bit, pin_match, cmd_known, apply_cmd, hit;

  // control
  logic      accept, slot_free, stall, step, emit;
  status_e   emit_status;
  logic      emit_ev, emit_el, emit_last;
  logic [IDX_W-1:0] emit_ep;
  status_e   final_status;

  // drive and pull vectors from the current pin store
  logic [VEC_W-1:0] de_vec, dl_vec, pu_vec, pd_vec;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_pin_mask_q <= MASK_RESET;
    end else if (cfg_we_i) begin
      usable_pin_mask_q <= cfg_wdata_i;
    end
  end

  // per-pin vector bits, each from its own pin entry
  always_comb begin
    de_vec = '0;
    dl_vec = '0;
    pu_vec = '0;
    pd_vec = '0;
    for (int p = 0; p < NUM_PINS; p++) begin
      de_vec[p] = (mode_q[p] == MODE_OUT_LOW) || (mode_q[p] == MODE_OUT_HIGH) ||
                  (mode_q[p] == MODE_BLINK_FAST) || (mode_q[p] == MODE_BLINK_SLOW);
      dl_vec[p] = (mode_q[p] == MODE_OUT_HIGH) ||
                  (((mode_q[p] == MODE_BLINK_FAST) || (mode_q[p] == MODE_BLINK_SLOW)) &&
                   level_q[p]);
      pu_vec[p] = (mode_q[p] == MODE_IN_PULLUP);
      pd_vec[p] = (mode_q[p] == MODE_IN_PULLDOWN);
    end
  end

  // command decode
  always_comb begin
    case (cmd_q)
      CMD_OUT_ENABLE, CMD_IN_FLOAT, CMD_IN_PULLUP, CMD_IN_PULLDOWN,
      CMD_DRIVE_LOW, CMD_DRIVE_HIGH, CMD_BLINK_SLOW, CMD_BLINK_FAST: cmd_known = 1'b1;
      default: cmd_known = 1'b0;
    endcase
  end

  // pin-update unit, working on the pin under the scan index
  assign mode_cur  = mode_q[idx_q];
  assign lvl_cur   = level_q[idx_q];
  assign ph_cur    = phase_q[idx_q];
  assign mask_bit  = usable_pin_mask_q[idx_q];
  assign pin_match = (PIN_W'(idx_q) == pin_q);
  assign apply_cmd = (req_q == REQ_CMD) && cmd_known && pin_match && mask_bit;
  assign hit       = (req_q == REQ_READ) && mask_bit &&
                     ((mode_cur == MODE_IN_FLOAT) || (mode_cur == MODE_IN_PULLUP) ||
                      (mode_cur == MODE_IN_PULLDOWN));

  always_comb begin
    mode_nx = mode_cur;
    lvl_nx  = lvl_cur;
    ph_nx   = ph_cur;
    case (req_q)
      REQ_CMD: begin
        if (apply_cmd) begin
          case (cmd_q)
            CMD_OUT_ENABLE: begin
              if (mode_cur != MODE_OUT_HIGH) mode_nx = MODE_OUT_LOW;
            end
            CMD_IN_FLOAT:    mode_nx = MODE_IN_FLOAT;
            CMD_IN_PULLUP:   mode_nx = MODE_IN_PULLUP;
            CMD_IN_PULLDOWN: mode_nx = MODE_IN_PULLDOWN;
            CMD_DRIVE_LOW:   mode_nx = MODE_OUT_LOW;
            CMD_DRIVE_HIGH:  mode_nx = MODE_OUT_HIGH;
            CMD_BLINK_SLOW: begin
              mode_nx = MODE_BLINK_SLOW;
              lvl_nx  = 1'b0;
              ph_nx   = 1'b0;
            end
            CMD_BLINK_FAST: begin
              mode_nx = MODE_BLINK_FAST;
              lvl_nx  = 1'b0;
              ph_nx   = 1'b0;
            end
            default: mode_nx = mode_cur;
          endcase
        end
      end
      REQ_TICK: begin
        // pins masked off stay frozen
        if (mask_bit && mode_cur == MODE_BLINK_FAST) begin
          lvl_nx = !lvl_cur;
        end else if (mask_bit && mode_cur == MODE_BLINK_SLOW) begin
          ph_nx = !ph_cur;
          if (ph_cur) lvl_nx = !lvl_cur;
        end
      end
      default: mode_nx = mode_cur;
    endcase
  end

  // status of a finished request
  always_comb begin
    case (req_q)
      REQ_CMD: begin
        if (!cmd_known)     final_status = ST_BAD_CMD;
        else if (!pin_ok_q) final_status = ST_BAD_PIN;
        else                final_status = ST_OK;
      end
      REQ_RSVD: final_status = ST_BAD_CMD;
      default:  final_status = ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE:   if (in_valid_i) state_d = SEQ_SCAN;
      SEQ_SCAN:   if (step && idx_q == LAST_IDX) state_d = SEQ_FINISH;
      SEQ_FINISH: if (slot_free) state_d = SEQ_IDLE;
      default:    state_d = SEQ_IDLE;
    endcase
  end

  // sequencer outputs: stepping, result word and held-back entry
  always_comb begin
    in_ready_o   = 1'b0;
    stall        = 1'b0;
    step         = 1'b0;
    emit         = 1'b0;
    emit_status  = ST_OK;
    emit_ev      = 1'b0;
    emit_ep      = '0;
    emit_el      = 1'b0;
    emit_last    = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_pin_d   = pend_pin_q;
    pend_level_d = pend_level_q;
    case (state_q)
      SEQ_IDLE: begin
        in_ready_o   = 1'b1;
        pend_valid_d = 1'b0;
      end
      SEQ_SCAN: begin
        stall = hit && pend_valid_q && !slot_free;
        step  = !stall;
        if (step && hit) begin
          // a new entry pushes the held one out as a non-final word
          emit         = pend_valid_q;
          emit_ev      = 1'b1;
          emit_ep      = pend_pin_q;
          emit_el      = pend_level_q;
          pend_valid_d = 1'b1;
          pend_pin_d   = idx_q;
          pend_level_d = levels_q[idx_q];
        end
      end
      SEQ_FINISH: begin
        emit        = slot_free;
        emit_status = final_status;
        emit_ev     = pend_valid_q;
        emit_ep     = pend_valid_q ? pend_pin_q : '0;
        emit_el     = pend_valid_q && pend_level_q;
        emit_last   = 1'b1;
        // the held entry leaves with the final word
        if (slot_free) pend_valid_d = 1'b0;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SEQ_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      pin_ok_q     <= 1'b0;
      req_q        <= REQ_CMD;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      if (accept) begin
        idx_q    <= '0;
        pin_ok_q <= 1'b0;
        req_q    <= req_e'(req_type_i);
      end else if (state_q == SEQ_SCAN && step) begin
        idx_q <= idx_q + 1'b1;
        if (pin_match && mask_bit) pin_ok_q <= 1'b1;
      end
    end
  end

  // request payload and held-back entry
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pin_q    <= pin_i;
      cmd_q    <= command_i;
      levels_q <= pin_levels_i;
    end
    pend_pin_q   <= pend_pin_d;
    pend_level_q <= pend_level_d;
  end

  // pin store, one entry updated per scan step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PINS; p++) begin
        mode_q[p]  <= MODE_UNSET;
        level_q[p] <= 1'b0;
        phase_q[p] <= 1'b0;
      end
    end else if (state_q == SEQ_SCAN && step) begin
      mode_q[idx_q]  <= mode_nx;
      level_q[idx_q] <= lvl_nx;
      phase_q[idx_q] <= ph_nx;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= emit_status;
      de_q     <= de_vec;
      dl_q     <= dl_vec;
      pu_q     <= pu_vec;
      pd_q     <= pd_vec;
      ev_q     <= emit_ev;
      ep_q     <= emit_ep;
      el_q     <= emit_el;
      last_q   <= emit_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign drive_enable_o     = de_q;
  assign drive_level_o      = dl_q;
  assign pull_up_enable_o   = pu_q;
  assign pull_down_enable_o = pd_q;
  assign entry_valid_o      = ev_q;
  assign entry_pin_o        = ENTRY_PIN_W'(ep_q);
  assign entry_level_o      = el_q;
  assign last_o             = last_q;

  // a word that is not the last of its request is always a read entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> entry_valid_o && status_o == ST_OK)
    else $error("non-final word without read entry");

  // no entry is held back between requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEQ_IDLE |-> !pend_valid_q)
    else $error("held entry left over in idle");

  // a reported pin is usable under the mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> usable_pin_mask_q[ep_q])
    else $error("entry reported for an unusable pin");

  // a pin never drives and pulls at the same time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (de_vec & (pu_vec | pd_vec)) == '0)
    else $error("pin both driven and pulled");

  // the scan never moves while an entry waits for the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SEQ_SCAN && stall |=> $stable(idx_q))
    else $error("scan index moved during a stall");

endmodule

`default_nettype wire

FILE: verif/gmb_result_checker.sv
// Result checker for the GPIO mode and blink controller: predicts and compares result words.
module gmb_result_checker (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [gmb_pkg::VEC_W-1:0]        cfg_wdata_i,
  input  wire                              in_valid_i,
  input  wire                              in_ready_i,
  input  wire  [1:0]                       req_type_i,
  input  wire  [gmb_pkg::PIN_W-1:0]        pin_i,
  input  wire  [gmb_pkg::CMD_W-1:0]        command_i,
  input  wire  [gmb_pkg::VEC_W-1:0]        pin_levels_i,
  input  wire                              out_valid_i,
  input  wire                              out_ready_i,
  input  wire  [1:0]                       status_i,
  input  wire  [gmb_pkg::VEC_W-1:0]        drive_enable_i,
  input  wire  [gmb_pkg::VEC_W-1:0]        drive_level_i,
  input  wire  [gmb_pkg::VEC_W-1:0]        pull_up_enable_i,
  input  wire  [gmb_pkg::VEC_W-1:0]        pull_down_enable_i,
  input  wire                              entry_valid_i,
  input  wire  [gmb_pkg::ENTRY_PIN_W-1:0]  entry_pin_i,
  input  wire                              entry_level_i,
  input  wire                              last_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import gmb_pkg::*;

  // One result word as the block presents it
  typedef struct packed {
    logic [1:0]             status;
    logic [VEC_W-1:0]       drv_en;
    logic [VEC_W-1:0]       drv_lvl;
    logic [VEC_W-1:0]       pull_up;
    logic [VEC_W-1:0]       pull_dn;
    logic                   ent_valid;
    logic [ENTRY_PIN_W-1:0] ent_pin;
    logic                   ent_lvl;
    logic                   last;
  } pin_word_t;

  // Shadow of the block's configuration and pin store
  logic [VEC_W-1:0]    usable_q;
  pin_mode_e           mode_q [NUM_PINS];
  logic [NUM_PINS-1:0] blink_lvl_q;
  logic [NUM_PINS-1:0] blink_phase_q;

  pin_word_t expected_words[$];
  int        n_fail  = 0;
  int        n_words = 0;

  function automatic logic pin_usable(input int p);
    return (p < NUM_PINS) ? usable_q[p] : 1'b0;
  endfunction

  // Build a word from the current pin modes plus the entry fields
  function automatic pin_word_t pin_word(input logic [1:0] st, input logic ev,
                                         input logic [ENTRY_PIN_W-1:0] ep,
                                         input logic el, input logic lst);
    pin_word_t w;
    w = '0;
    for (int p = 0; p < NUM_PINS; p++) begin
      w.drv_en[p]  = mode_q[p] >= MODE_OUT_LOW;
      w.drv_lvl[p] = (mode_q[p] == MODE_OUT_HIGH) ||
                     (mode_q[p] >= MODE_BLINK_FAST && blink_lvl_q[p]);
      w.pull_up[p] = mode_q[p] == MODE_IN_PULLUP;
      w.pull_dn[p] = mode_q[p] == MODE_IN_PULLDOWN;
    end
    w.status    = st;
    w.ent_valid = ev;
    w.ent_pin   = ep;
    w.ent_lvl   = el;
    w.last      = lst;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    if (n_fail < 40) $display("[%0t] word %0d: %s", $time, n_words, what);
    n_fail++;
  endtask

  task automatic check_field(input string name, input logic [VEC_W-1:0] got,
                             input logic [VEC_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    pin_word_t got;
    pin_word_t want;
    pin_word_t held;
    logic      have_held;
    logic [1:0] st;
    int        p;
    if (!rst_ni) begin
      usable_q = MASK_RESET;
      for (int q = 0; q < NUM_PINS; q++) mode_q[q] = MODE_UNSET;
      blink_lvl_q   = '0;
      blink_phase_q = '0;
      expected_words.delete();
      pending_o    <= 0;
      fail_count_o <= n_fail;
    end else begin
      // Compare a delivered word with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        got.status    = status_i;
        got.drv_en    = drive_enable_i;
        got.drv_lvl   = drive_level_i;
        got.pull_up   = pull_up_enable_i;
        got.pull_dn   = pull_down_enable_i;
        got.ent_valid = entry_valid_i;
        got.ent_pin   = entry_pin_i;
        got.ent_lvl   = entry_level_i;
        got.last      = last_i;
        if (expected_words.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = expected_words.pop_front();
          check_field("status", VEC_W'(got.status), VEC_W'(want.status));
          check_field("drive_enable", got.drv_en, want.drv_en);
          check_field("drive_level", got.drv_lvl, want.drv_lvl);
          check_field("pull_up_enable", got.pull_up, want.pull_up);
          check_field("pull_down_enable", got.pull_dn, want.pull_dn);
          check_field("entry_valid", VEC_W'(got.ent_valid), VEC_W'(want.ent_valid));
          check_field("entry_pin", VEC_W'(got.ent_pin), VEC_W'(want.ent_pin));
          check_field("entry_level", VEC_W'(got.ent_lvl), VEC_W'(want.ent_lvl));
          check_field("last", VEC_W'(got.last), VEC_W'(want.last));
        end
        n_words++;
      end

      if (cfg_we_i) usable_q = cfg_wdata_i;

      // Predict the words of an accepted request
      if (in_valid_i && in_ready_i) begin
        p = int'(pin_i);
        case (req_e'(req_type_i))
          REQ_CMD: begin
            if (!(command_i <= CMD_IN_PULLDOWN ||
                  (command_i >= CMD_DRIVE_LOW && command_i <= CMD_BLINK_FAST))) begin
              st = ST_BAD_CMD;
            end else if (!pin_usable(p)) begin
              st = ST_BAD_PIN;
            end else begin
              st = ST_OK;
              case (command_i)
                CMD_OUT_ENABLE: begin
                  if (mode_q[p] != MODE_OUT_HIGH) mode_q[p] = MODE_OUT_LOW;
                end
                CMD_IN_FLOAT:    mode_q[p] = MODE_IN_FLOAT;
                CMD_IN_PULLUP:   mode_q[p] = MODE_IN_PULLUP;
                CMD_IN_PULLDOWN: mode_q[p] = MODE_IN_PULLDOWN;
                CMD_DRIVE_LOW:   mode_q[p] = MODE_OUT_LOW;
                CMD_DRIVE_HIGH:  mode_q[p] = MODE_OUT_HIGH;
                default: begin
                  // either blink rate restarts the pin from low, phase zero
                  mode_q[p] = (command_i == CMD_BLINK_SLOW) ? MODE_BLINK_SLOW
                                                            : MODE_BLINK_FAST;
                  blink_lvl_q[p]   = 1'b0;
                  blink_phase_q[p] = 1'b0;
                end
              endcase
            end
            expected_words.push_back(pin_word(st, 1'b0, '0, 1'b0, 1'b1));
          end
          REQ_TICK: begin
            // pins masked off keep their blink state frozen
            for (int q = 0; q < NUM_PINS; q++) begin
              if (pin_usable(q)) begin
                if (mode_q[q] == MODE_BLINK_FAST) begin
                  blink_lvl_q[q] = ~blink_lvl_q[q];
                end else if (mode_q[q] == MODE_BLINK_SLOW) begin
                  if (blink_phase_q[q]) blink_lvl_q[q] = ~blink_lvl_q[q];
                  blink_phase_q[q] = ~blink_phase_q[q];
                end
              end
            end
            expected_words.push_back(pin_word(ST_OK, 1'b0, '0, 1'b0, 1'b1));
          end
          REQ_READ: begin
            // hold each entry back until the next one shows it is not the last
            have_held = 1'b0;
            held      = '0;
            for (int q = 0; q < NUM_PINS; q++) begin
              if (pin_usable(q) && mode_q[q] >= MODE_IN_FLOAT &&
                  mode_q[q] <= MODE_IN_PULLDOWN) begin
                if (have_held) expected_words.push_back(held);
                held = pin_word(ST_OK, 1'b1, ENTRY_PIN_W'(q), pin_levels_i[q], 1'b0);
                have_held = 1'b1;
              end
            end
            if (have_held) begin
              held.last = 1'b1;
              expected_words.push_back(held);
            end else begin
              expected_words.push_back(pin_word(ST_OK, 1'b0, '0, 1'b0, 1'b1));
            end
          end
          default: expected_words.push_back(pin_word(ST_BAD_CMD, 1'b0, '0, 1'b0, 1'b1));
        endcase
      end

      pending_o    <= expected_words.size();
      fail_count_o <= n_fail;
    end
  end

endmodule

FILE: verif/gpio_mode_blink_controller_tb.sv
// Testbench top for the GPIO mode and blink controller: stimulus, stalls and verdict.
module gpio_mode_blink_controller_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import gmb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = NUM_PINS + 8;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_e;

  logic                   clk_i     = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [VEC_W-1:0]       cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [1:0]             req_type  = REQ_CMD;
  logic [PIN_W-1:0]       pin       = '0;
  logic [CMD_W-1:0]       command   = '0;
  logic [VEC_W-1:0]       pin_levels = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [VEC_W-1:0]       drive_enable;
  logic [VEC_W-1:0]       drive_level;
  logic [VEC_W-1:0]       pull_up_enable;
  logic [VEC_W-1:0]       pull_down_enable;
  logic                   entry_valid;
  logic [ENTRY_PIN_W-1:0] entry_pin;
  logic                   entry_level;
  logic                   last;

  int               fail_count;
  int               pending;
  int               cycles      = 0;
  int               burst_left  = 0;
  int               stall_phase = 0;
  logic             gaps_on     = 1'b0;
  stall_mode_e      stall_mode  = STALL_NONE;
  logic [VEC_W-1:0] cur_mask    = MASK_RESET;

  always #2 clk_i = ~clk_i;

  gpio_mode_blink_controller dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .req_type_i         (req_type),
    .pin_i              (pin),
    .command_i          (command),
    .pin_levels_i       (pin_levels),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .status_o           (status),
    .drive_enable_o     (drive_enable),
    .drive_level_o      (drive_level),
    .pull_up_enable_o   (pull_up_enable),
    .pull_down_enable_o (pull_down_enable),
    .entry_valid_o      (entry_valid),
    .entry_pin_o        (entry_pin),
    .entry_level_o      (entry_level),
    .last_o             (last)
  );

  gmb_result_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .req_type_i         (req_type),
    .pin_i              (pin),
    .command_i          (command),
    .pin_levels_i       (pin_levels),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .status_i           (status),
    .drive_enable_i     (drive_enable),
    .drive_level_i      (drive_level),
    .pull_up_enable_i   (pull_up_enable),
    .pull_down_enable_i (pull_down_enable),
    .entry_valid_i      (entry_valid),
    .entry_pin_i        (entry_pin),
    .entry_level_i      (entry_level),
    .last_i             (last),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result-side back-pressure
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase == 10) ? 0 : stall_phase + 1;
      case (stall_mode)
        STALL_NONE:   out_ready <= 1'b1;
        STALL_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:      out_ready <= (stall_phase < 6);
      endcase
    end
  end

  // Present one request word and hold it until taken; gaps fall between bursts
  task automatic send_req(input req_e rt, input logic [PIN_W-1:0] p,
                          input logic [CMD_W-1:0] c, input logic [VEC_W-1:0] lv);
    int gap;
    in_valid   <= 1'b1;
    req_type   <= rt;
    pin        <= p;
    command    <= c;
    pin_levels <= lv;
    do @(posedge clk_i); while (!in_ready);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        gap        = $urandom_range(1, 6);
        in_valid  <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop sending and wait for every expected word, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [VEC_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    cur_mask   = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed commands on usable pins, with ticks, reads and noise
  task automatic rand_req();
    int               r;
    int               tries;
    logic [PIN_W-1:0] p;
    logic [CMD_W-1:0] c;
    logic [VEC_W-1:0] lv;
    r  = $urandom_range(0, 99);
    lv = {8'($urandom), $urandom};
    if (r < 45) begin
      p = PIN_W'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 8) begin
        tries = 0;
        do begin
          p = PIN_W'($urandom_range(0, NUM_PINS - 1));
          tries++;
        end while (!cur_mask[p] && tries < 64);
      end
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 7))
          0:       c = CMD_OUT_ENABLE;
          1:       c = CMD_IN_FLOAT;
          2:       c = CMD_IN_PULLUP;
          3:       c = CMD_IN_PULLDOWN;
          4:       c = CMD_DRIVE_LOW;
          5:       c = CMD_DRIVE_HIGH;
          6:       c = CMD_BLINK_SLOW;
          default: c = CMD_BLINK_FAST;
        endcase
      end else begin
        c = CMD_W'($urandom_range(0, 255));
      end
      send_req(REQ_CMD, p, c, lv);
    end else if (r < 70) begin
      send_req(REQ_TICK, PIN_W'($urandom), CMD_W'($urandom), lv);
    end else if (r < 95) begin
      send_req(REQ_READ, PIN_W'($urandom), CMD_W'($urandom), lv);
    end else begin
      send_req(REQ_RSVD, PIN_W'($urandom), CMD_W'($urandom), lv);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset mask, no idling on either side
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    send_req(REQ_READ, '0, '0, '1);                  // no input pins yet
    send_req(REQ_CMD, 8'd2, CMD_OUT_ENABLE, '0);
    send_req(REQ_CMD, 8'd4, CMD_DRIVE_HIGH, '0);
    send_req(REQ_CMD, 8'd4, CMD_OUT_ENABLE, '0);     // stays high
    send_req(REQ_CMD, 8'd5, CMD_DRIVE_LOW, '0);
    send_req(REQ_CMD, 8'd12, CMD_IN_FLOAT, '0);
    send_req(REQ_CMD, 8'd13, CMD_IN_PULLUP, '0);
    send_req(REQ_CMD, 8'd39, CMD_IN_PULLDOWN, '0);
    send_req(REQ_CMD, 8'd14, CMD_BLINK_SLOW, '0);
    send_req(REQ_CMD, 8'd15, CMD_BLINK_FAST, '0);
    repeat (3) send_req(REQ_TICK, '0, '0, '0);
    send_req(REQ_CMD, 8'd15, CMD_BLINK_FAST, '0);    // restarts a running blink
    send_req(REQ_TICK, '1, '1, '1);
    send_req(REQ_READ, '0, '0, '1);
    send_req(REQ_READ, '1, '1, '0);
    send_req(REQ_READ, '0, '0, 40'h55_5555_5555);
    send_req(REQ_CMD, 8'd2, 8'd4, '0);               // unknown command codes
    send_req(REQ_CMD, 8'd255, 8'd255, '0);
    send_req(REQ_CMD, 8'd2, 8'd14, '0);
    send_req(REQ_CMD, 8'd0, CMD_IN_FLOAT, '0);       // masked-off pin
    send_req(REQ_CMD, 8'd40, CMD_DRIVE_HIGH, '0);    // beyond the pin count
    send_req(REQ_CMD, 8'd255, CMD_BLINK_FAST, '0);
    send_req(REQ_RSVD, '0, '0, '0);
    drain();

    // Every pin usable
    write_mask('1);
    stall_mode = STALL_RANDOM;
    gaps_on    = 1'b1;
    repeat (30) rand_req();
    drain();

    // No pin usable: every command refused, blink frozen
    write_mask('0);
    stall_mode = STALL_PATTERN;
    repeat (10) rand_req();
    drain();

    // Random mask
    write_mask({8'($urandom), $urandom});
    stall_mode = STALL_RANDOM;
    repeat (20) rand_req();
    drain();

    // Back to the reset mask
    write_mask(MASK_RESET);
    stall_mode = STALL_PATTERN;
    gaps_on    = 1'b0;
    repeat (20) rand_req();
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
